// ===== rtl/btrx_pkg.sv =====
// btrx_pkg: shared types and constants of the bus telegram receiver
// used by btrx_decode and bus_telegram_receiver; no dependencies
`default_nettype none

package btrx_pkg;

    // payload length of an update-data telegram
    localparam int PACKET_BYTES = 32;
    localparam int CNT_W        = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

    // line symbols
    localparam logic [7:0] SYM_STX  = 8'h02;
    localparam logic [7:0] SYM_ESC  = 8'h1B;
    localparam logic [7:0] SUM_SEED = 8'h55;
    localparam logic [7:0] SUM_START = SUM_SEED + SYM_STX;

    // configuration register indexes
    localparam logic [1:0] CFG_TYPE_REBOOT = 2'd0;
    localparam logic [1:0] CFG_TYPE_ENTER  = 2'd1;
    localparam logic [1:0] CFG_TYPE_DATA   = 2'd2;
    localparam logic [1:0] CFG_TYPE_TERM   = 2'd3;

    localparam int OUT_W = 56;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SENDER,
        FS_TYPE,
        FS_RECEIVER,
        FS_ADDR_LO,
        FS_ADDR_HI,
        FS_PAYLOAD,
        FS_CHECK
    } t_frame_state;

    typedef enum logic [1:0] {
        STS_NONE = 2'd0,
        STS_OK   = 2'd1,
        STS_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] type_reboot;
        logic [7:0] type_enter;
        logic [7:0] type_data;
        logic [7:0] type_term;
    } t_cfg;

    typedef struct packed {
        t_frame_state     state;
        logic             esc;
        logic [7:0]       sum;
        logic [7:0]       sender;
        logic [7:0]       msg_type;
        logic [7:0]       receiver;
        logic [15:0]      word_addr;
        logic [CNT_W-1:0] count;
    } t_ctx;

    // first member in the highest bits: status ends up at bit 0
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [4:0]  data_index;
        logic        data_valid;
        logic [15:0] word_addr;
        logic [7:0]  receiver_addr;
        logic [7:0]  msg_type;
        logic [7:0]  sender_addr;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/btrx_decode.sv =====
// btrx_decode: one-byte step of the telegram decoder, purely combinational
// depends on btrx_pkg
`default_nettype none

module btrx_decode (
    input  wire btrx_pkg::t_ctx    i_ctx,
    input  wire btrx_pkg::t_cfg    i_cfg,
    input  wire logic [7:0]        i_byte,
    output btrx_pkg::t_ctx         o_ctx,
    output btrx_pkg::t_result      o_result
);

    logic [7:0] w_byte;
    logic       w_plain;
    logic       w_is_data;
    logic       w_is_short;
    logic       w_reg_data;
    logic       w_reg_short;
    logic       w_last;

    // a byte that is neither STX nor ESC while a telegram is open
    assign w_plain = (i_ctx.state != btrx_pkg::FS_IDLE) &&
                     (i_byte != btrx_pkg::SYM_ESC) && (i_byte != btrx_pkg::SYM_STX);
    assign w_byte  = i_ctx.esc ? ~i_byte : i_byte;

    assign w_is_data  = (w_byte == i_cfg.type_data);
    assign w_is_short = (w_byte == i_cfg.type_reboot) || (w_byte == i_cfg.type_enter) ||
                        (w_byte == i_cfg.type_term);
    assign w_reg_data  = (i_ctx.msg_type == i_cfg.type_data);
    assign w_reg_short = (i_ctx.msg_type == i_cfg.type_reboot) ||
                         (i_ctx.msg_type == i_cfg.type_enter) ||
                         (i_ctx.msg_type == i_cfg.type_term);
    assign w_last = (i_ctx.count == btrx_pkg::CNT_W'(btrx_pkg::PACKET_BYTES - 1));

    // next context
    always_comb begin
        o_ctx = i_ctx;
        if (i_ctx.state == btrx_pkg::FS_IDLE) begin
            if (i_byte == btrx_pkg::SYM_STX) begin
                o_ctx.sum   = btrx_pkg::SUM_START;
                o_ctx.esc   = 1'b0;
                o_ctx.state = btrx_pkg::FS_SENDER;
            end
        end else if (i_byte == btrx_pkg::SYM_ESC) begin
            o_ctx.esc = 1'b1;
        end else if (i_byte == btrx_pkg::SYM_STX) begin
            o_ctx.esc   = 1'b0;
            o_ctx.sum   = btrx_pkg::SUM_START;
            o_ctx.state = btrx_pkg::FS_SENDER;
        end else begin
            o_ctx.esc = 1'b0;
            o_ctx.sum = i_ctx.sum + w_byte;
            case (i_ctx.state)
                btrx_pkg::FS_SENDER: begin
                    o_ctx.sender = w_byte;
                    o_ctx.state  = btrx_pkg::FS_TYPE;
                end
                btrx_pkg::FS_TYPE: begin
                    o_ctx.msg_type = w_byte;
                    o_ctx.state    = (w_is_data || w_is_short) ? btrx_pkg::FS_RECEIVER
                                                               : btrx_pkg::FS_IDLE;
                end
                btrx_pkg::FS_RECEIVER: begin
                    o_ctx.receiver = w_byte;
                    if (w_reg_data) begin
                        o_ctx.state = btrx_pkg::FS_ADDR_LO;
                    end else if (w_reg_short) begin
                        o_ctx.state = btrx_pkg::FS_CHECK;
                    end else begin
                        o_ctx.state = btrx_pkg::FS_IDLE;
                    end
                end
                btrx_pkg::FS_ADDR_LO: begin
                    o_ctx.word_addr = {8'h00, w_byte};
                    o_ctx.state     = btrx_pkg::FS_ADDR_HI;
                end
                btrx_pkg::FS_ADDR_HI: begin
                    o_ctx.word_addr = {w_byte, i_ctx.word_addr[7:0]};
                    o_ctx.count     = '0;
                    o_ctx.state     = btrx_pkg::FS_PAYLOAD;
                end
                btrx_pkg::FS_PAYLOAD: begin
                    if (w_last) begin
                        o_ctx.count = '0;
                        o_ctx.state = btrx_pkg::FS_CHECK;
                    end else begin
                        o_ctx.count = i_ctx.count + 1'b1;
                    end
                end
                btrx_pkg::FS_CHECK: begin
                    o_ctx.state = btrx_pkg::FS_IDLE;
                end
                default: begin
                    o_ctx.state = btrx_pkg::FS_IDLE;
                end
            endcase
        end
    end

    // result of this byte
    always_comb begin
        o_result.status        = btrx_pkg::STS_NONE;
        o_result.data_valid    = 1'b0;
        o_result.data_index    = '0;
        o_result.data_byte     = '0;
        o_result.sender_addr   = o_ctx.sender;
        o_result.msg_type      = o_ctx.msg_type;
        o_result.receiver_addr = o_ctx.receiver;
        o_result.word_addr     = o_ctx.word_addr;
        if ((i_ctx.state != btrx_pkg::FS_IDLE) && (i_byte == btrx_pkg::SYM_STX)) begin
            o_result.status = btrx_pkg::STS_ERR;
        end else if (w_plain) begin
            case (i_ctx.state)
                btrx_pkg::FS_PAYLOAD: begin
                    o_result.data_valid = 1'b1;
                    o_result.data_index = 5'(i_ctx.count);
                    o_result.data_byte  = w_byte;
                end
                btrx_pkg::FS_CHECK: begin
                    o_result.status = (w_byte == i_ctx.sum) ? btrx_pkg::STS_OK
                                                            : btrx_pkg::STS_ERR;
                end
                default: begin
                    o_result.status = btrx_pkg::STS_NONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bus_telegram_receiver.sv =====
// bus_telegram_receiver: top level of the telegram deframer with checksum
// depends on btrx_pkg and btrx_decode
//
// usage
// - s_axis carries one raw line byte per transfer in s_axis_tdata[7:0]
// - m_axis returns exactly one result per accepted byte: status, header
//   fields, word address and, for payload bytes, the unstuffed byte and
//   its index within the packet; the consumer drops payload on an error
// - the cfg channel writes the four type codes (index 0 reboot, 1 update
//   enter, 2 update data, 3 update terminate) and is always ready; it is to
//   be written only while no byte is in flight, not enforced by the block
// - the result is registered, valid in the cycle after the byte transfer;
//   throughput is one byte per cycle while m_axis does not stall, set by
//   the combinational decode step feeding one result register
// - when m_axis stalls the result register holds and s_axis_tready drops
//   only while that register is full and not being drained; a new byte is
//   taken in the same cycle the waiting result is transferred
// - reset (i_rst_n low, synchronous) returns the decoder to idle, clears
//   the header fields and checksum, empties the result register and loads
//   the default type codes 0, 1, 2, 3
`default_nettype none

module bus_telegram_receiver (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input byte stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,  // rx_byte
    // result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // status[1:0], sender_addr[9:2], msg_type[17:10], receiver_addr[25:18],
    // word_addr[41:26], data_valid[42], data_index[47:43], data_byte[55:48]
    output logic [btrx_pkg::OUT_W-1:0]        m_axis_tdata,
    // configuration writes
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [7:0]                   i_cfg_data
);

    btrx_pkg::t_cfg    r_cfg;
    btrx_pkg::t_ctx    r_ctx;
    btrx_pkg::t_ctx    n_ctx;
    btrx_pkg::t_result n_result;
    btrx_pkg::t_result r_result;
    logic              r_out_valid;
    logic              w_s_fire;
    logic              w_cfg_fire;

    assign o_cfg_ready   = 1'b1;
    assign w_cfg_fire    = i_cfg_valid && o_cfg_ready;
    // result register frees up when it is empty or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_result;

    // type code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.type_reboot <= 8'd0;
            r_cfg.type_enter  <= 8'd1;
            r_cfg.type_data   <= 8'd2;
            r_cfg.type_term   <= 8'd3;
        end else if (w_cfg_fire) begin
            case (i_cfg_index)
                btrx_pkg::CFG_TYPE_REBOOT: r_cfg.type_reboot <= i_cfg_data;
                btrx_pkg::CFG_TYPE_ENTER:  r_cfg.type_enter  <= i_cfg_data;
                btrx_pkg::CFG_TYPE_DATA:   r_cfg.type_data   <= i_cfg_data;
                btrx_pkg::CFG_TYPE_TERM:   r_cfg.type_term   <= i_cfg_data;
                default:                   r_cfg.type_term   <= r_cfg.type_term;
            endcase
        end
    end

    btrx_decode u_decode (
        .i_ctx    (r_ctx),
        .i_cfg    (r_cfg),
        .i_byte   (s_axis_tdata),
        .o_ctx    (n_ctx),
        .o_result (n_result)
    );

    // decoder context advances on every byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state     <= btrx_pkg::FS_IDLE;
            r_ctx.esc       <= 1'b0;
            r_ctx.sum       <= '0;
            r_ctx.sender    <= '0;
            r_ctx.msg_type  <= '0;
            r_ctx.receiver  <= '0;
            r_ctx.word_addr <= '0;
            r_ctx.count     <= '0;
        end else if (w_s_fire) begin
            r_ctx <= n_ctx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_result <= n_result;
        end
    end

    // idle ignores everything but a start byte
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire && (r_ctx.state == btrx_pkg::FS_IDLE) &&
        (s_axis_tdata != btrx_pkg::SYM_STX) |=> (r_ctx.state == btrx_pkg::FS_IDLE))
        else $error("decoder left idle without a start byte");

    // a valid telegram is only reported from the checksum byte
    a_ok_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire && (r_ctx.state != btrx_pkg::FS_CHECK) |=>
        (r_result.status != btrx_pkg::STS_OK))
        else $error("ok status outside the checksum byte");

    // payload results never carry a status
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.data_valid |-> (r_result.status == btrx_pkg::STS_NONE))
        else $error("payload result with nonzero status");

    // no pending escape while idle
    a_idle_no_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctx.state == btrx_pkg::FS_IDLE) |-> !r_ctx.esc)
        else $error("escape pending in idle");

    // a full, stalled result register blocks the input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> $stable(r_result))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire
